// ===== design/fdl_pkg.sv =====
// Shared constants, types and helpers for the feedback delay line.
// Used by every module of the block except fdl_ram; no dependencies of its own.
package fdl_pkg;

  // Sizing of the sample store and of the data path
  localparam int MAX_DELAY_SAMPLES = 262144;
  localparam int SAMPLE_BITS       = 24;
  localparam int FRACTION_BITS     = 8;

  // Configuration register widths and port sizing
  localparam int BUF_LEN_W   = 19;
  localparam int DELAY_W     = 27;
  localparam int GAIN_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 27;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_Q8      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX       = 2'd3;

  // Register reset values
  localparam logic [BUF_LEN_W-1:0] RST_BUFFER_LENGTH = 19'd240000;
  localparam logic [DELAY_W-1:0]   RST_DELAY_Q8      = 27'd12288000;
  localparam logic [GAIN_W-1:0]    RST_FEEDBACK_GAIN = 16'd0;
  localparam logic [GAIN_W-1:0]    RST_WET_MIX       = 16'd32768;

  // Q1.15 unity gain, one bit wider than the gain registers
  localparam int GAIN_FULL_W = GAIN_W + 1;
  localparam logic [GAIN_FULL_W-1:0] UNITY_Q15 = 17'd32768;
  localparam int GAIN_SHIFT = 15;

  // Width of the value handed to the saturation helper
  localparam int SAT_IN_W = 48;

  // Commands from the controller to the data path
  typedef struct packed {
    logic load_in;    // latch the dry sample and the raw read offset
    logic calc_pos;   // resolve the wrapped read position
    logic calc_next;  // form the neighbor index, qualify the first entry
    logic cap_lo;     // take the first entry, read the neighbor
    logic cap_hi;     // take the neighbor entry
    logic calc_wet;   // interpolate
    logic calc_mul;   // form the gain products
    logic commit;     // load the result, write the store, advance
    logic reject;     // load the delay-too-long result
  } fdl_cmd_t;

  // Status from the data path to the controller
  typedef struct packed {
    logic too_long;   // delay exceeds the length in use
    logic out_free;   // output register can take a word
  } fdl_stat_t;

  // Clamp a wide signed value to the signed sample range
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [SAT_IN_W-1:0] v
  );
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    hi = SAT_IN_W'(signed'({1'b0, {(SAMPLE_BITS-1){1'b1}}}));
    lo = -hi - SAT_IN_W'(1);
    if (v > hi) begin
      sat_sample = hi[SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      sat_sample = lo[SAMPLE_BITS-1:0];
    end else begin
      sat_sample = v[SAMPLE_BITS-1:0];
    end
  endfunction

endpackage

// ===== design/fdl_sample_if.sv =====
// Input channel: one signed audio sample per word.
// Depends on fdl_pkg for the sample width.
interface fdl_sample_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [fdl_pkg::SAMPLE_BITS-1:0]  sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== design/fdl_result_if.sv =====
// Output channel: mixed sample plus the delay-too-long flag.
// Depends on fdl_pkg for the sample width.
interface fdl_result_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [fdl_pkg::SAMPLE_BITS-1:0]  sample_out;
  logic                                    delay_too_long;

  modport source (output valid, output sample_out, output delay_too_long, input ready);
  modport sink   (input valid, input sample_out, input delay_too_long, output ready);
endinterface

// ===== design/fdl_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on fdl_pkg for the index and data widths.
interface fdl_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [fdl_pkg::CFG_IDX_W-1:0]       index;
  logic [fdl_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/feedback_delay_line_interp.sv =====
// Feedback delay line with linear interpolation: controller plus data path.
// Each accepted word steps through position, two sequential store reads, interpolate,
// multiply and commit; a too-long delay goes straight to a reject. A new word is taken
// only after the last is done, and a result still waiting holds the next commit or reject.
// Reset: config registers take their defaults, pointer goes to zero, and the store
// reads as zero by tracking the written region; no clearing pass.
module feedback_delay_line_interp #(
  parameter int MAX_DELAY_SAMPLES = fdl_pkg::MAX_DELAY_SAMPLES
) (
  input  logic         clk,
  input  logic         rst,
  fdl_sample_if.sink   sample,
  fdl_result_if.source result,
  fdl_cfg_if.sink      cfg
);

  fdl_pkg::fdl_cmd_t  cmd;
  fdl_pkg::fdl_stat_t stat;

  // Register writes are always taken
  assign cfg.ready = 1'b1;

  fdl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fdl_datapath #(
    .MAX_DEPTH (MAX_DELAY_SAMPLES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .sample_in  (sample.sample_in),
    .cfg_valid  (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_sample (result.sample_out),
    .out_flag   (result.delay_too_long)
  );

endmodule

// ===== design/fdl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
module fdl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/fdl_ctrl.sv =====
// Sequencer for the delay line: steps one word through the data path.
// Depends on fdl_pkg for the command and status structs.
module fdl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fdl_pkg::fdl_stat_t stat,
  output fdl_pkg::fdl_cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_POS  = 4'd1;
  localparam logic [3:0] ST_RD0  = 4'd2;
  localparam logic [3:0] ST_RD1  = 4'd3;
  localparam logic [3:0] ST_CAP1 = 4'd4;
  localparam logic [3:0] ST_WET  = 4'd5;
  localparam logic [3:0] ST_MUL  = 4'd6;
  localparam logic [3:0] ST_DONE = 4'd7;
  localparam logic [3:0] ST_ERR  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  // Decode commands and the next state
  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = stat.too_long ? ST_ERR : ST_POS;
        end
      end
      ST_POS: begin
        cmd.calc_pos = 1'b1;
        state_next   = ST_RD0;
      end
      ST_RD0: begin
        cmd.calc_next = 1'b1;
        state_next    = ST_RD1;
      end
      ST_RD1: begin
        cmd.cap_lo = 1'b1;
        state_next = ST_CAP1;
      end
      ST_CAP1: begin
        cmd.cap_hi = 1'b1;
        state_next = ST_WET;
      end
      ST_WET: begin
        cmd.calc_wet = 1'b1;
        state_next   = ST_MUL;
      end
      ST_MUL: begin
        cmd.calc_mul = 1'b1;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register frees up
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (stat.out_free) begin
          cmd.reject = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/fdl_datapath.sv =====
// Data path: config registers, pointer, store, interpolation, mixing, output word.
// Depends on fdl_pkg and fdl_ram.
module fdl_datapath #(
  parameter int MAX_DEPTH = fdl_pkg::MAX_DELAY_SAMPLES
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  fdl_pkg::fdl_cmd_t                      cmd,
  output fdl_pkg::fdl_stat_t                     stat,
  input  logic signed [fdl_pkg::SAMPLE_BITS-1:0] sample_in,
  input  logic                                   cfg_valid,
  input  logic [fdl_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [fdl_pkg::CFG_DATA_W-1:0]         cfg_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [fdl_pkg::SAMPLE_BITS-1:0] out_sample,
  output logic                                   out_flag
);

  localparam int SB     = fdl_pkg::SAMPLE_BITS;
  localparam int FB     = fdl_pkg::FRACTION_BITS;
  localparam int AW     = $clog2(MAX_DEPTH);
  localparam int LEN_W  = $clog2(MAX_DEPTH + 1);
  localparam int CMP_W  = (LEN_W > fdl_pkg::BUF_LEN_W) ? LEN_W : fdl_pkg::BUF_LEN_W;
  localparam int FX_W   = LEN_W + FB;
  localparam int DW     = ((fdl_pkg::DELAY_W > FX_W) ? fdl_pkg::DELAY_W : FX_W) + 1;
  localparam int GW     = fdl_pkg::GAIN_FULL_W;
  localparam int PW     = SB + GW + 1;
  localparam int ACC_W  = SB + FB + 3;
  localparam int SAT_W  = fdl_pkg::SAT_IN_W;

  // Configuration registers
  logic [fdl_pkg::BUF_LEN_W-1:0] buffer_length;
  logic [fdl_pkg::DELAY_W-1:0]   delay_q8;
  logic [fdl_pkg::GAIN_W-1:0]    feedback_gain;
  logic [fdl_pkg::GAIN_W-1:0]    wet_mix;

  // Write pointer and written-region tracking
  logic [AW-1:0] wp;
  logic          wrapped;

  // Per-word working registers
  logic signed [SB-1:0]  dry;
  logic signed [DW-1:0]  diff;
  logic [AW-1:0]         i0;
  logic [AW-1:0]         i1;
  logic [FB-1:0]         frac;
  logic                  v0;
  logic                  v1;
  logic signed [SB-1:0]  y0;
  logic signed [SB-1:0]  y1;
  logic signed [SB-1:0]  wet;
  logic signed [PW-1:0]  prod_dry;
  logic signed [PW-1:0]  prod_wet;
  logic signed [PW-1:0]  prod_fb;

  // Combinational helpers
  logic [CMP_W-1:0]      len_cmp;
  logic [LEN_W-1:0]      len;
  logic [FX_W-1:0]       len_fx;
  logic signed [DW-1:0]  pos;
  logic [LEN_W-1:0]      i0_inc;
  logic [LEN_W-1:0]      wp_inc;
  logic [GW-1:0]         wm;
  logic [GW-1:0]         fg;
  logic [GW-1:0]         dm;
  logic signed [SB:0]    y_step;
  logic signed [ACC_W-1:0] acc;
  logic signed [PW:0]    mix_sum;
  logic signed [PW-1:0]  fb_sh;
  logic signed [PW:0]    store_sum;
  logic signed [SB-1:0]  mix_sat;
  logic signed [SB-1:0]  store_sat;
  logic [AW-1:0]         raddr;
  logic [SB-1:0]         rdata;

  // Length in use: zero acts as one, clamp to the store depth
  always_comb begin
    if (buffer_length == '0) begin
      len_cmp = CMP_W'(1);
    end else if (CMP_W'(buffer_length) > CMP_W'(MAX_DEPTH)) begin
      len_cmp = CMP_W'(MAX_DEPTH);
    end else begin
      len_cmp = CMP_W'(buffer_length);
    end
  end
  assign len    = len_cmp[LEN_W-1:0];
  assign len_fx = {len, {FB{1'b0}}};

  // Delay check against the length in fixed point
  assign stat.too_long = DW'(delay_q8) > DW'(len_fx);
  assign stat.out_free = !out_valid || out_ready;

  // Wrap the read position into the circular range
  assign pos = (diff < 0) ? (diff + $signed(DW'(len_fx))) : diff;

  assign i0_inc = LEN_W'(i0) + LEN_W'(1);
  assign wp_inc = LEN_W'(wp) + LEN_W'(1);

  // Clamp gains to unity
  assign wm = (GW'(wet_mix) > fdl_pkg::UNITY_Q15) ? fdl_pkg::UNITY_Q15 : GW'(wet_mix);
  assign fg = (GW'(feedback_gain) > fdl_pkg::UNITY_Q15) ?
              fdl_pkg::UNITY_Q15 : GW'(feedback_gain);
  assign dm = fdl_pkg::UNITY_Q15 - wm;

  // Linear interpolation between the two neighbors
  assign y_step = $signed({y1[SB-1], y1}) - $signed({y0[SB-1], y0});
  assign acc    = ACC_W'($signed({y0, {FB{1'b0}}})) +
                  ACC_W'(y_step * $signed({1'b0, frac}));

  // Final sums with floor shift and saturation
  assign mix_sum   = $signed({prod_dry[PW-1], prod_dry}) + $signed({prod_wet[PW-1], prod_wet});
  assign fb_sh     = prod_fb >>> fdl_pkg::GAIN_SHIFT;
  assign store_sum = $signed({fb_sh[PW-1], fb_sh}) + (PW+1)'(dry);
  assign mix_sat   = fdl_pkg::sat_sample(SAT_W'(mix_sum >>> fdl_pkg::GAIN_SHIFT));
  assign store_sat = fdl_pkg::sat_sample(SAT_W'(store_sum));

  // Read the first neighbor, then the second while the first is captured
  assign raddr = cmd.cap_lo ? i1 : i0;

  fdl_ram #(
    .WIDTH (SB),
    .DEPTH (MAX_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (wp),
    .wdata (store_sat),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Configuration, pointer and written-region tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_length <= fdl_pkg::RST_BUFFER_LENGTH;
      delay_q8      <= fdl_pkg::RST_DELAY_Q8;
      feedback_gain <= fdl_pkg::RST_FEEDBACK_GAIN;
      wet_mix       <= fdl_pkg::RST_WET_MIX;
      wp            <= '0;
      wrapped       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          fdl_pkg::REG_BUFFER_LENGTH: begin
            // a length write empties the store: nothing counts as written
            buffer_length <= cfg_data[fdl_pkg::BUF_LEN_W-1:0];
            wp            <= '0;
            wrapped       <= 1'b0;
          end
          fdl_pkg::REG_DELAY_Q8:      delay_q8      <= cfg_data[fdl_pkg::DELAY_W-1:0];
          fdl_pkg::REG_FEEDBACK_GAIN: feedback_gain <= cfg_data[fdl_pkg::GAIN_W-1:0];
          fdl_pkg::REG_WET_MIX:       wet_mix       <= cfg_data[fdl_pkg::GAIN_W-1:0];
          default: begin
          end
        endcase
      end else if (cmd.commit) begin
        // advance the pointer modulo the length
        if (wp_inc == len) begin
          wp      <= '0;
          wrapped <= 1'b1;
        end else begin
          wp <= wp_inc[AW-1:0];
        end
      end
    end
  end

  // Working registers for one word
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dry  <= sample_in;
      diff <= $signed(DW'({wp, {FB{1'b0}}})) - $signed(DW'(delay_q8));
    end
    if (cmd.calc_pos) begin
      i0   <= pos[FB +: AW];
      frac <= pos[FB-1:0];
    end
    if (cmd.calc_next) begin
      i1 <= (i0_inc == len) ? '0 : i0_inc[AW-1:0];
      v0 <= wrapped || (i0 < wp);
    end
    if (cmd.cap_lo) begin
      // entries never written since the last clear read as zero
      y0 <= v0 ? $signed(rdata) : '0;
      v1 <= wrapped || (i1 < wp);
    end
    if (cmd.cap_hi) begin
      y1 <= v1 ? $signed(rdata) : '0;
    end
    if (cmd.calc_wet) begin
      wet <= acc[FB +: SB];
    end
    if (cmd.calc_mul) begin
      prod_dry <= dry * $signed({1'b0, dm});
      prod_wet <= wet * $signed({1'b0, wm});
      prod_fb  <= wet * $signed({1'b0, fg});
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit || cmd.reject) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_sample <= mix_sat;
      out_flag   <= 1'b0;
    end else if (cmd.reject) begin
      out_sample <= '0;
      out_flag   <= 1'b1;
    end
  end

endmodule
